>>> design/pmio_pkg.sv
`timescale 1ns / 1ps
package pmio_pkg;

  localparam int unsigned PageBitsDef    = 13;
  localparam int unsigned RamAddrBitsDef = 19;

  // I/O register addresses
  localparam logic [15:0] AddrVdgMode  = 16'hFF22;
  localparam logic [15:0] AddrInit0    = 16'hFF90;
  localparam logic [15:0] AddrInit1    = 16'hFF91;
  localparam logic [15:0] AddrIrq      = 16'hFF92;
  localparam logic [15:0] AddrFirq     = 16'hFF93;
  localparam logic [15:0] AddrTimerHi  = 16'hFF94;
  localparam logic [15:0] AddrTimerLo  = 16'hFF95;
  localparam logic [15:0] AddrVidMode  = 16'hFF98;
  localparam logic [15:0] AddrBorder   = 16'hFF9A;
  localparam logic [15:0] AddrVScroll  = 16'hFF9C;
  localparam logic [15:0] AddrVOffLo   = 16'hFF9D;
  localparam logic [15:0] AddrVOffHi   = 16'hFF9E;
  localparam logic [15:0] AddrHReg     = 16'hFF9F;
  localparam logic [15:0] AddrRstVecHi = 16'hFFFE;
  localparam logic [15:0] AddrRstVecLo = 16'hFFFF;

  localparam logic [15:0] AddrExecPt   = 16'hFFA0;
  localparam logic [15:0] AddrTaskPt   = 16'hFFA8;
  localparam logic [15:0] AddrPalette  = 16'hFFB0;
  localparam logic [15:0] AddrSamLo    = 16'hFFC0;
  localparam logic [15:0] AddrSamHi    = 16'hFFC5;
  localparam logic [15:0] AddrDispLo   = 16'hFFC6;
  localparam logic [15:0] AddrDispHi   = 16'hFFD3;
  localparam logic [15:0] AddrRateLo   = 16'hFFD6;
  localparam logic [15:0] AddrRateHi   = 16'hFFDF;

  localparam logic [7:0] FixedPageBase = 8'h38;
  localparam logic [7:0] RamFill       = 8'h80;
  localparam logic [7:0] SamReset      = 8'h40;

endpackage

>>> design/pmio_ram.sv
`timescale 1ns / 1ps
module pmio_ram #(
  parameter int unsigned Width    = 8,
  parameter int unsigned AddrBits = 19
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem [2**AddrBits];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem[raddr_i];
  end

endmodule

>>> design/paged_mmu_io_register_decoder_unit.sv
`timescale 1ns / 1ps
// Paged MMU with an I/O register page; one byte bus access per input beat.
// Input beat: tuser is the access kind (0 read, 1 write); tdata carries the
// address, write byte and the current keyboard row and column bytes.
// Output beat: the byte read (or written back), RAM hit flag and physical
// address, timer load strobe and count, IRQ/FIRQ acknowledges and the CPU
// clock rate bits after the access.
// Register state updates when the input beat is taken; a RAM read returns
// from the synchronous RAM, so the result passes through pend_q and then
// the output register (m_axis_tdata, out_valid_q) before it is offered. The
// unit holds one access at a time: no new beat is taken while pend_q is set,
// and with the receiver ready the next beat is taken as the result is taken.
// If the receiver stalls, the result register holds and s_axis_tready stays
// low until the result is taken.
// After reset the RAM is swept to 0x80, one byte per cycle, over all
// 2**RAM_ADDR_BITS bytes (524288 by default); no input beat is taken during
// the sweep. The reset vector write port is live whenever reset is released.
module paged_mmu_io_register_decoder_unit #(
  parameter int unsigned PAGE_BITS     = pmio_pkg::PageBitsDef,
  parameter int unsigned RAM_ADDR_BITS = pmio_pkg::RamAddrBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] bus_address, [23:16] write_data, [31:24] key_row, [39:32] key_column
  input  logic [39:0] s_axis_tdata,
  // [0] command
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data, ram_access, physical_address, timer_load, timer_count,
  // irq_ack, firq_ack, clock_rate, zero fill
  output logic [((RAM_ADDR_BITS+37)/8)*8-1:0] m_axis_tdata
);
  import pmio_pkg::*;

  localparam int unsigned RA    = RAM_ADDR_BITS;
  localparam int unsigned OutW  = ((RA + 37) / 8) * 8;
  localparam int unsigned PhysW = 8 + PAGE_BITS;

  // sweep counter and handshake state
  logic [RA:0] clr_q;
  logic        clr_done;
  logic        pend_q, out_valid_q;
  logic        acc;

  // register file
  logic [7:0]  exec_pt_q [8];
  logic [7:0]  task_pt_q [8];
  logic [7:0]  pal_q [16];
  logic [5:0]  init_q, init_d;
  logic [7:0]  irq_q, irq_d, firq_q, firq_d;
  logic [15:0] timer_q, timer_d;
  logic [7:0]  vdg_q, vdg_d, border_q, border_d, voff_lo_q, voff_lo_d;
  logic [7:0]  voff_hi_q, voff_hi_d, hreg_q, hreg_d;
  logic [3:0]  vscr_q, vscr_d;
  logic        altpal_q, altpal_d;
  logic [6:0]  disp_q, disp_d;
  logic [7:0]  sam_q, sam_d;
  logic [15:0] rstvec_q;

  // pending result
  logic [7:0]    p_rd_q, rd;
  logic          p_ram_q, ramhit;
  logic          p_memrd_q;
  logic [RA-1:0] p_phys_q, phys;
  logic          p_tload_q, tload;
  logic [15:0]   p_tcount_q, tcount;
  logic          p_iack_q, iack, p_fack_q, fack;
  logic [1:0]    p_rate_q;

  logic        wr;
  logic [15:0] a;
  logic [7:0]  v, row, col;
  logic [2:0]  vp, pt_idx, sbit;
  logic [7:0]  pt_rd, pp, off_c6;
  logic [PhysW-1:0] phys_full;
  logic [31:0] phys_w;
  logic        pt_we_exec, pt_we_task, pal_we;
  logic [7:0]  ram_rdata;
  logic        ram_we, ram_re;
  logic [RA-1:0] ram_waddr;
  logic [7:0]  ram_wdata;
  logic [15:0] vp_full;

  assign wr  = s_axis_tuser;
  assign a   = s_axis_tdata[15:0];
  assign v   = s_axis_tdata[23:16];
  assign row = s_axis_tdata[31:24];
  assign col = s_axis_tdata[39:32];

  assign clr_done      = clr_q[RA];
  assign s_axis_tready = clr_done && !pend_q && (!out_valid_q || m_axis_tready);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  // address translation
  assign vp_full = a >> PAGE_BITS;
  assign vp      = vp_full[2:0];
  assign pt_idx  = (a[15:4] == 12'hFFA) ? a[2:0] : vp;
  assign pt_rd   = (init_q[5] && !(a[15:3] == AddrExecPt[15:3])) ||
                   (a[15:3] == AddrTaskPt[15:3]) ? task_pt_q[pt_idx] : exec_pt_q[pt_idx];
  assign pp      = init_q[1] ? pt_rd : FixedPageBase + 8'(vp_full);
  assign phys_full = {pp, a[PAGE_BITS-1:0]};
  assign phys_w    = 32'(phys_full);
  assign off_c6    = a[7:0] - AddrDispLo[7:0];

  always_comb begin
    init_d = init_q;  irq_d = irq_q;  firq_d = firq_q;  timer_d = timer_q;
    vdg_d = vdg_q;  border_d = border_q;  voff_lo_d = voff_lo_q;
    voff_hi_d = voff_hi_q;  hreg_d = hreg_q;  vscr_d = vscr_q;
    altpal_d = altpal_q;  disp_d = disp_q;  sam_d = sam_q;
    rd = '0;  ramhit = 1'b0;  phys = '0;  tload = 1'b0;  tcount = '0;
    iack = 1'b0;  fack = 1'b0;
    pt_we_exec = 1'b0;  pt_we_task = 1'b0;  pal_we = 1'b0;
    sbit = '0;
    if (a == 16'hFF00 || a == 16'hFF04 || a == 16'hFF08 || a == 16'hFF0C) begin
      rd = row;
    end else if (a == 16'hFF02 || a == 16'hFF06 || a == 16'hFF0A || a == 16'hFF0E) begin
      rd = col;
    end else if (a == AddrVdgMode) begin
      if (wr) vdg_d = v;
      rd = vdg_d;
    end else if (a == AddrInit0) begin
      if (wr) begin
        init_d[3:0] = {v[4], v[5], v[6], v[7]};
        if (!init_d[2]) irq_d = '0;
        if (!init_d[3]) firq_d = '0;
      end
      rd = {init_d[0], init_d[1], init_d[2], init_d[3], 4'b0};
    end else if (a == AddrInit1) begin
      if (wr) init_d[5:4] = {v[0], v[5]};
      rd = {2'b0, init_d[4], 4'b0, init_d[5]};
    end else if (a == AddrIrq) begin
      if (wr) irq_d = v;
      rd = irq_d;
      if (!wr && init_q[2]) begin
        irq_d = '0;
        iack  = 1'b1;
      end
    end else if (a == AddrFirq) begin
      if (wr) firq_d = v;
      rd = firq_d;
      if (!wr && init_q[3]) begin
        firq_d = '0;
        fack   = 1'b1;
      end
    end else if (a == AddrTimerHi || a == AddrTimerLo) begin
      if (wr) begin
        if (a == AddrTimerHi) timer_d[15:8] = v;
        else timer_d[7:0] = v;
        tload  = 1'b1;
        tcount = timer_d;
      end
      rd = (a == AddrTimerHi) ? timer_d[15:8] : timer_d[7:0];
    end else if (a == AddrVidMode) begin
      if (wr) begin
        init_d[0] = v[7];
        altpal_d  = v[5];
      end
      rd = {init_d[0], 1'b0, altpal_d, 5'b0};
    end else if (a == AddrBorder) begin
      if (wr) border_d = v;
      rd = border_d;
    end else if (a == AddrVScroll) begin
      if (wr) vscr_d = v[3:0];
      rd = {4'b0, vscr_d};
    end else if (a == AddrVOffLo) begin
      if (wr) voff_lo_d = v;
      rd = voff_lo_d;
    end else if (a == AddrVOffHi) begin
      if (wr) voff_hi_d = v;
      rd = voff_hi_d;
    end else if (a == AddrHReg) begin
      if (wr) hreg_d = v;
      rd = hreg_d;
    end else if (a[15:3] == AddrExecPt[15:3]) begin
      pt_we_exec = wr;
      rd = wr ? v : pt_rd;
    end else if (a[15:3] == AddrTaskPt[15:3]) begin
      pt_we_task = wr;
      rd = wr ? v : pt_rd;
    end else if (a[15:4] == AddrPalette[15:4]) begin
      pal_we = wr;
      rd = wr ? v : pal_q[a[3:0]];
    end else if (a >= AddrSamLo && a <= AddrSamHi) begin
      sbit = {1'b0, a[2:1]};
      if (wr) sam_d[sbit] = !a[0];
      rd = {7'b0, sam_d[sbit]};
    end else if (a >= AddrDispLo && a <= AddrDispHi) begin
      if (wr) disp_d[off_c6[3:1]] = !a[0];
      rd = {7'b0, disp_d[off_c6[3:1]]};
    end else if (a >= AddrRateLo && a <= AddrRateHi) begin
      sbit = 3'd3 + 3'(a[3:1] - AddrRateLo[3:1]);
      if (wr) sam_d[sbit] = a[0];
      rd = {7'b0, sam_d[sbit]};
    end else if (a == AddrRstVecHi) begin
      rd = rstvec_q[15:8];
    end else if (a == AddrRstVecLo) begin
      rd = rstvec_q[7:0];
    end else begin
      ramhit = 1'b1;
      phys   = phys_w[RA-1:0];
      rd     = v;
    end
  end

  // RAM: sweep owns the write port until done
  assign ram_we    = !clr_done || (acc && ramhit && wr);
  assign ram_waddr = clr_done ? phys : clr_q[RA-1:0];
  assign ram_wdata = clr_done ? v : RamFill;
  assign ram_re    = acc && ramhit && !wr;

  pmio_ram #(.Width(8), .AddrBits(RA)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (phys),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      init_q      <= '0;
      irq_q       <= '0;
      firq_q      <= '0;
      timer_q     <= '0;
      vdg_q       <= '0;
      border_q    <= '0;
      voff_lo_q   <= '0;
      voff_hi_q   <= '0;
      hreg_q      <= '0;
      vscr_q      <= '0;
      altpal_q    <= 1'b0;
      disp_q      <= '0;
      sam_q       <= SamReset;
      rstvec_q    <= '0;
      for (int i = 0; i < 8; i++) begin
        exec_pt_q[i] <= '0;
        task_pt_q[i] <= '0;
      end
      for (int i = 0; i < 16; i++) pal_q[i] <= '0;
    end else begin
      if (!clr_done) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) rstvec_q <= cfg_wdata_i;
      if (acc) begin
        init_q    <= init_d;
        irq_q     <= irq_d;
        firq_q    <= firq_d;
        timer_q   <= timer_d;
        vdg_q     <= vdg_d;
        border_q  <= border_d;
        voff_lo_q <= voff_lo_d;
        voff_hi_q <= voff_hi_d;
        hreg_q    <= hreg_d;
        vscr_q    <= vscr_d;
        altpal_q  <= altpal_d;
        disp_q    <= disp_d;
        sam_q     <= sam_d;
        if (pt_we_exec) exec_pt_q[a[2:0]] <= v;
        if (pt_we_task) task_pt_q[a[2:0]] <= v;
        if (pal_we) pal_q[a[3:0]] <= v;
      end
      pend_q <= acc;
      if (pend_q) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      p_rd_q     <= rd;
      p_ram_q    <= ramhit;
      p_memrd_q  <= ramhit && !wr;
      p_phys_q   <= phys;
      p_tload_q  <= tload;
      p_tcount_q <= tcount;
      p_iack_q   <= iack;
      p_fack_q   <= fack;
      p_rate_q   <= sam_d[4:3];
    end
    if (pend_q) begin
      m_axis_tdata <= OutW'({p_rate_q, p_fack_q, p_iack_q, p_tcount_q, p_tload_q,
                             p_phys_q, p_ram_q, p_memrd_q ? ram_rdata : p_rd_q});
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import pmio_pkg::*;

  localparam int unsigned ItemCount = 1050;
  localparam int unsigned CycleLimit = 2_000_000;

  // Predicts each access of the paged MMU and checks the result beats in order.
  class mmu_access_scoreboard;
    logic [55:0] expected_beats[$];
    int unsigned errors;
    bit [7:0] ram[int];
    bit [7:0] exec_pt[8];
    bit [7:0] task_pt[8];
    bit [7:0] palette[16];
    bit [5:0] init_flags;
    bit [7:0] irq_src, firq_src;
    bit [15:0] timer_latch;
    bit [7:0] vdg_mode, border, voff_lo, voff_hi, hreg;
    bit [3:0] vscroll;
    bit alt_pal;
    bit [15:0] disp_start;
    bit [7:0] sam;
    bit [15:0] rst_vec;

    function new();
      errors = 0;
      init_flags = '0;
      irq_src = '0;
      firq_src = '0;
      timer_latch = '0;
      {vdg_mode, border, voff_lo, voff_hi, hreg} = '0;
      vscroll = '0;
      alt_pal = 1'b0;
      disp_start = '0;
      sam = SamReset;
      rst_vec = '0;
      foreach (exec_pt[i]) begin
        exec_pt[i] = '0;
        task_pt[i] = '0;
      end
      foreach (palette[i]) palette[i] = '0;
    endfunction

    function void set_reset_vector(bit [15:0] val);
      rst_vec = val;
    endfunction

    function void note_access(bit wr, bit [15:0] a, bit [7:0] v, bit [7:0] row, bit [7:0] col);
      bit [7:0] rd;
      bit hit, tload, iack, fack;
      bit [18:0] phys;
      bit [15:0] tcount;
      bit [2:0] vp, bi;
      bit [7:0] pp;
      bit [20:0] sum;
      int p;
      rd = '0; hit = 0; tload = 0; iack = 0; fack = 0; phys = '0; tcount = '0;
      if (a == 16'hFF00 || a == 16'hFF04 || a == 16'hFF08 || a == 16'hFF0C) begin
        rd = row;
      end else if (a == 16'hFF02 || a == 16'hFF06 || a == 16'hFF0A || a == 16'hFF0E) begin
        rd = col;
      end else if (a == AddrVdgMode) begin
        if (wr) vdg_mode = v;
        rd = vdg_mode;
      end else if (a == AddrInit0) begin
        if (wr) begin
          init_flags[3:0] = {v[4], v[5], v[6], v[7]};
          if (!init_flags[2]) irq_src = '0;
          if (!init_flags[3]) firq_src = '0;
        end
        rd = {init_flags[0], init_flags[1], init_flags[2], init_flags[3], 4'b0};
      end else if (a == AddrInit1) begin
        if (wr) init_flags[5:4] = {v[0], v[5]};
        rd = {2'b0, init_flags[4], 4'b0, init_flags[5]};
      end else if (a == AddrIrq) begin
        if (wr) irq_src = v;
        rd = irq_src;
        if (!wr && init_flags[2]) begin
          irq_src = '0;
          iack = 1;
        end
      end else if (a == AddrFirq) begin
        if (wr) firq_src = v;
        rd = firq_src;
        if (!wr && init_flags[3]) begin
          firq_src = '0;
          fack = 1;
        end
      end else if (a == AddrTimerHi || a == AddrTimerLo) begin
        if (wr) begin
          if (a == AddrTimerHi) timer_latch[15:8] = v;
          else timer_latch[7:0] = v;
          tload = 1;
          tcount = timer_latch;
        end
        rd = (a == AddrTimerHi) ? timer_latch[15:8] : timer_latch[7:0];
      end else if (a == AddrVidMode) begin
        if (wr) begin
          init_flags[0] = v[7];
          alt_pal = v[5];
        end
        rd = {init_flags[0], 1'b0, alt_pal, 5'b0};
      end else if (a == AddrBorder) begin
        if (wr) border = v;
        rd = border;
      end else if (a == AddrVScroll) begin
        if (wr) vscroll = v[3:0];
        rd = {4'b0, vscroll};
      end else if (a == AddrVOffLo) begin
        if (wr) voff_lo = v;
        rd = voff_lo;
      end else if (a == AddrVOffHi) begin
        if (wr) voff_hi = v;
        rd = voff_hi;
      end else if (a == AddrHReg) begin
        if (wr) hreg = v;
        rd = hreg;
      end else if (a >= AddrExecPt && a < AddrTaskPt) begin
        if (wr) exec_pt[a[2:0]] = v;
        rd = exec_pt[a[2:0]];
      end else if (a >= AddrTaskPt && a < AddrPalette) begin
        if (wr) task_pt[a[2:0]] = v;
        rd = task_pt[a[2:0]];
      end else if (a >= AddrPalette && a <= 16'hFFBF) begin
        if (wr) palette[a[3:0]] = v;
        rd = palette[a[3:0]];
      end else if (a >= AddrSamLo && a <= AddrSamHi) begin
        bi = 3'((a - AddrSamLo) >> 1);
        if (wr) sam[bi] = !a[0];
        rd = {7'b0, sam[bi]};
      end else if (a >= AddrDispLo && a <= AddrDispHi) begin
        p = 9 + ((a - AddrDispLo) >> 1);
        if (wr) disp_start[p] = !a[0];
        rd = {7'b0, disp_start[p]};
      end else if (a >= AddrRateLo && a <= AddrRateHi) begin
        p = 3 + ((a - AddrRateLo) >> 1);
        // odd address sets, even clears
        if (wr) sam[p] = a[0];
        rd = {7'b0, sam[p]};
      end else if (a == AddrRstVecHi) begin
        rd = rst_vec[15:8];
      end else if (a == AddrRstVecLo) begin
        rd = rst_vec[7:0];
      end else begin
        vp = a[15:13];
        if (init_flags[1]) pp = init_flags[5] ? task_pt[vp] : exec_pt[vp];
        else pp = FixedPageBase + vp;
        sum = {pp, 13'b0} + a[12:0];
        phys = sum[18:0];
        if (wr) ram[phys] = v;
        rd = ram.exists(phys) ? ram[phys] : RamFill;
        hit = 1;
      end
      expected_beats.push_back({7'b0, sam[4:3], fack, iack, tcount, tload, phys, hit, rd});
    endfunction

    function void cmp_field(string name, logic [31:0] e, logic [31:0] g);
      if (e !== g) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, g);
      end
    endfunction

    function void check_result(logic [55:0] got);
      logic [55:0] e;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none actual %0h", $time, got);
        return;
      end
      e = expected_beats.pop_front();
      cmp_field("read_data", e[7:0], got[7:0]);
      cmp_field("ram_access", e[8], got[8]);
      cmp_field("physical_address", e[27:9], got[27:9]);
      cmp_field("timer_load", e[28], got[28]);
      cmp_field("timer_count", e[44:29], got[44:29]);
      cmp_field("irq_ack", e[45], got[45]);
      cmp_field("firq_ack", e[46], got[46]);
      cmp_field("clock_rate", e[48:47], got[48:47]);
      cmp_field("zero_fill", e[55:49], got[55:49]);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles = 0;
  mmu_access_scoreboard sb = new();

  paged_mmu_io_register_decoder_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_access(bit wr, bit [15:0] a, bit [7:0] v);
    bit [7:0] row, col;
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    row = 8'($urandom);
    col = 8'($urandom);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = wr;
    s_axis_tdata = {col, row, v, a};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_access(wr, a, v, row, col);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reset_vector(bit [15:0] val);
    cfg_we_i = 1'b1;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reset_vector(val);
  endtask

  function automatic bit [15:0] pick_address();
    bit [15:0] regs[14] = '{AddrVdgMode, AddrInit0, AddrInit1, AddrIrq, AddrFirq,
                            AddrTimerHi, AddrTimerLo, AddrVidMode, AddrBorder,
                            AddrVScroll, AddrVOffLo, AddrVOffHi, AddrHReg, 16'hFF00};
    case ($urandom_range(9))
      0: return {12'hFF0, 2'($urandom_range(3)), 1'($urandom_range(1)), 1'b0};
      1, 2: return regs[$urandom_range(13)];
      3: return AddrExecPt + 16'($urandom_range(31));
      4: return AddrSamLo + 16'($urandom_range(31));
      5: return $urandom_range(1) ? AddrRstVecHi : AddrRstVecLo;
      6: return {8'hFF, 8'($urandom)};
      7: return {3'($urandom), 10'b0, 3'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_random(int unsigned n, bit hold_once);
    for (int unsigned i = 0; i < n; i++) begin
      if (hold_once && i == n / 2) drain();
      send_access(1'($urandom_range(1)), pick_address(), 8'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    write_reset_vector(16'hFFFF);

    // directed: ports, interrupts, timer, set/clear pairs, paging
    send_access(1, 16'hFF00, 8'hFF);
    send_access(0, 16'hFF0E, 8'h00);
    send_access(1, AddrRstVecHi, 8'h12);
    send_access(0, AddrRstVecLo, 8'h00);
    send_access(1, AddrInit0, 8'hFF);
    send_access(1, AddrIrq, 8'hA5);
    send_access(0, AddrIrq, 8'h00);
    send_access(1, AddrFirq, 8'h5A);
    send_access(1, AddrInit0, 8'h00);
    send_access(0, AddrFirq, 8'h00);
    send_access(1, AddrTimerHi, 8'hFF);
    send_access(1, AddrTimerLo, 8'h01);
    send_access(1, 16'hFFC1, 8'h00);
    send_access(0, 16'hFFC0, 8'h00);
    send_access(1, AddrDispHi, 8'h00);
    send_access(1, AddrRateHi, 8'h00);
    send_access(1, 16'h0000, 8'h00);
    send_access(1, 16'hFEFF, 8'hFF);
    send_access(1, AddrExecPt + 16'd7, 8'hFF);
    send_access(1, AddrTaskPt, 8'h00);
    send_access(1, AddrInit0, 8'h40);
    send_access(0, 16'hFEFF, 8'h00);
    send_access(1, AddrInit1, 8'h21);
    send_access(0, 16'h1FFF, 8'h00);
    send_access(1, AddrHReg, 8'h80);
    drain();

    write_reset_vector(16'h0000);
    gap_pct = 0; stall_pct = 0;
    run_random(ItemCount / 4, 0);
    drain();
    write_reset_vector(16'($urandom));
    gap_pct = 55; stall_pct = 0;
    run_random(ItemCount / 4, 1);
    drain();
    write_reset_vector(16'hFFFF);
    gap_pct = 0; stall_pct = 55;
    run_random(ItemCount / 4, 0);
    drain();
    write_reset_vector(16'($urandom));
    gap_pct = 30; stall_pct = 30;
    run_random(ItemCount / 4, 0);
    drain();
    repeat (10) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
